// File: design/cbf_pkg.sv
// Shared constants, types and the bytewise CRC-32 step for the block absorber.
// No dependencies; imported by cbf_absorb and crc32_block_folding.
package cbf_pkg;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam int          BLOCK_BYTES = 16;
  localparam int          CNT_W       = $clog2(BLOCK_BYTES + 1);

  // Byte count of one block, 0 to BLOCK_BYTES.
  typedef logic [CNT_W-1:0] cnt_t;

  // One byte absorbed into a reflected CRC register, low bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

endpackage

// File: design/crc32_block_folding.sv
// Path: a word is captured in the input stage, and a last word's result is then registered on out_*.
// Throughput: one 16-byte word per cycle, set by the remainder feedback loop through a
// combinational XOR matrix over sixteen bytes; only a stalled result holds a last word back.
// Reset (synchronous, rst_n low) empties both stages and clears the running remainder to
// zero, which matches a seed of 0xFFFFFFFF. No clearing pass is needed.
// Depends on cbf_pkg and cbf_absorb.
module crc32_block_folding (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_low,
  input  logic [63:0] in_data_high,
  input  logic [4:0]  in_byte_count,
  input  logic        in_first_block,
  input  logic        in_last_block,
  input  logic [31:0] in_seed_crc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_crc_value
);
  import cbf_pkg::*;

  // Input stage: one word waiting for the remainder update.
  logic        s1_valid_r, s1_valid_nxt;
  logic [63:0] s1_data_low_r;
  logic [63:0] s1_data_high_r;
  logic [4:0]  s1_count_r;
  logic        s1_first_r;
  logic        s1_last_r;
  logic [31:0] s1_seed_r;

  // Running CRC register (uninverted) and the result register.
  logic [31:0] rem_r, rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_crc_r, out_crc_nxt;

  logic        in_accept;
  logic        s1_fire;
  cnt_t        eff_count;
  logic [31:0] crc_start;
  logic [31:0] crc_done;

  // A non-last word never needs the result register, so it moves on even when
  // the output side is stalled. A last word waits until the result slot frees up.
  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  // Only a last word honors its byte count; anything above a full block saturates.
  always_comb begin
    if (!s1_last_r || (s1_count_r > 5'(BLOCK_BYTES))) begin
      eff_count = cnt_t'(BLOCK_BYTES);
    end else begin
      eff_count = cnt_t'(s1_count_r);
    end
  end

  // A first word starts from the inverted seed instead of the running remainder.
  assign crc_start = s1_first_r ? ~s1_seed_r : rem_r;

  cbf_absorb u_absorb (
    .crc_in     (crc_start),
    .data_low   (s1_data_low_r),
    .data_high  (s1_data_high_r),
    .byte_count (eff_count),
    .crc_out    (crc_done)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // The remainder keeps its value after a last word, so a later word without
  // the first flag continues from the finished CRC.
  always_comb begin
    rem_nxt = rem_r;
    if (s1_fire) begin
      rem_nxt = crc_done;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_crc_nxt   = out_crc_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
      out_crc_nxt   = ~crc_done;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= 32'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_low_r  <= in_data_low;
      s1_data_high_r <= in_data_high;
      s1_count_r     <= in_byte_count;
      s1_first_r     <= in_first_block;
      s1_last_r      <= in_last_block;
      s1_seed_r      <= in_seed_crc;
    end
    out_crc_r <= out_crc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

`ifndef ASSERT_OFF
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> out_valid_r && (out_crc_r == ~rem_r))
    else $error("last word did not produce its result");

  a_rem_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(rem_r))
    else $error("remainder changed without a word being absorbed");

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked last word");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && !(s1_fire && s1_last_r) |=> $stable(out_crc_r))
    else $error("pending result overwritten");
`endif

endmodule

// File: design/cbf_absorb.sv
// XOR network that absorbs up to sixteen message bytes into a CRC register.
// Depends on cbf_pkg for the byte step and the byte count type.
module cbf_absorb (
  input  logic [31:0]  crc_in,
  input  logic [63:0]  data_low,
  input  logic [63:0]  data_high,
  input  cbf_pkg::cnt_t byte_count,
  output logic [31:0]  crc_out
);
  import cbf_pkg::*;

  logic [8*BLOCK_BYTES-1:0] block;
  logic [31:0]              tap [0:BLOCK_BYTES];

  assign block  = {data_high, data_low};
  assign tap[0] = crc_in;

  // Each lane absorbs one byte; the whole chain collapses into a linear XOR matrix.
  for (genvar g = 0; g < BLOCK_BYTES; g++) begin : g_lane
    assign tap[g+1] = crc_byte(tap[g], block[8*g +: 8]);
  end

  // The count has already been limited to BLOCK_BYTES by the caller.
  assign crc_out = tap[byte_count];

endmodule
